FILE: rtl/lik_pkg.sv
package lik_pkg;

  // Default build values of the top-level parameters.
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_BITS_DEF = 16;

  // Largest CORDIC step count that the arctangent table covers.
  localparam int ATAN_ENTRIES = 24;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_LINK_LENGTHS = 3'd0;
  localparam logic [2:0] REG_FRAME_ROW_X = 3'd1;
  localparam logic [2:0] REG_FRAME_ROW_Y = 3'd2;
  localparam logic [2:0] REG_FRAME_ROW_Z = 3'd3;
  localparam logic [2:0] REG_KNEE_REVERSE = 3'd4;

  // Angles are carried in 32-bit binary units, 2^31 is pi.
  localparam logic signed [63:0] PI_UNITS = 64'sd2147483648;
  localparam logic signed [63:0] NORM_LIMIT = 64'sd1099511627776;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_MUL,
    ST_SQRT,
    ST_NORM,
    ST_ROT,
    ST_HALVE,
    ST_STORE,
    ST_DONE
  } state_t;

  // Steps of the solution sequence.
  typedef enum logic [4:0] {
    SP_MAP0,
    SP_MAP1,
    SP_MAP2,
    SP_S0,
    SP_S1,
    SP_SUM,
    SP_SQS,
    SP_B0,
    SP_B1,
    SP_TF0,
    SP_TF1,
    SP_HALVE,
    SP_PQ,
    SP_SQH,
    SP_FF,
    SP_TT,
    SP_V0,
    SP_V1,
    SP_V2,
    SP_V3,
    SP_DONE
  } step_t;

  // Which shared unit a step runs on.
  typedef enum logic [2:0] {
    K_MUL,
    K_SQRT,
    K_VEC,
    K_HALVE,
    K_DONE
  } kind_t;

  // Sign-extends a 16-bit field.
  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return 64'(signed'(v));
  endfunction

  // Rounds a 32-bit binary angle to 16 bits, wrapping.
  function automatic logic [15:0] to16(input logic [63:0] a);
    logic [63:0] r;
    r = a + 64'd32768;
    return r[31:16];
  endfunction

  // Arctangent of 2^-i in 32-bit binary units.
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/leg_inverse_kinematics_unit.sv
// Leg inverse kinematics for a coxa, femur and tibia joint chain.
// The host writes the link lengths, the three rows of the base-frame
// transform and the knee direction through cfg_we, cfg_index and cfg_data
// while the block is idle. A target point arrives on the s_t* stream
// (x, y, z in s_tdata); one result per point leaves on the m_t* stream with
// the three joint angles in m_tdata and the reachable flag in m_tuser.
// One point is worked on at a time. The work runs through a single
// bit-serial multiplier (one multiplier bit per cycle, for each of 19
// products), a one-bit-per-cycle square root unit (used twice) and a
// CORDIC vectoring unit (normalizing doublings plus CORDIC_STEPS
// rotations, capped at ATAN_ENTRIES, used up to four times), plus a
// launch and a store state per operation. An unreachable point ends early.
// The finished result sits in an output register, so the next point is
// accepted while the receiver stalls; that point completes and then waits
// until the earlier result has been taken.
// Reset (rst, synchronous) clears all configuration registers, the held
// hip angle and the output valid.
module leg_inverse_kinematics_unit #(
  parameter int CORDIC_STEPS = lik_pkg::CORDIC_STEPS_DEF,
  parameter int COORD_BITS = lik_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Fields from bit 0 up: target_x[15:0], target_y[15:0], target_z[15:0].
  input  logic [47:0] s_tdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0 up: hip_angle[15:0], upper_angle[15:0], lower_angle[15:0].
  output logic [47:0] m_tdata,
  // Fields from bit 0 up: reachable.
  output logic        m_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import lik_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam logic [4:0] LAST_STEP = 5'(NSTEPS - 1);
  localparam logic signed [63:0] LIM_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] LIM_LO = -(64'sd1 <<< (COORD_BITS - 1));
  localparam logic signed [63:0] HALF_LIMIT = 64'sd2147483648;

  // Configuration and held state.
  logic [47:0] link_lengths;
  logic [63:0] frame_row [0:2];
  logic        knee_reverse;
  logic [15:0] last_hip_angle;

  // Sequencer.
  state_t state, state_next;
  step_t  step;
  logic [1:0] row;
  logic       ok;

  // Latched target and mapped coordinates.
  logic signed [15:0] tx, ty, tz;
  logic signed [COORD_BITS-1:0] pc [0:2];

  // Working values of the solution.
  logic [63:0]        s_val;
  logic signed [63:0] d, b2, p, q, h2, u, tibia, femur, hip_ang;
  logic [5:0]         sh;

  // Bit-serial multiplier.
  logic signed [63:0] m_acc, m_cand;
  logic [31:0]        m_plier;
  logic [4:0]         m_cnt;

  // Bit-serial square root.
  logic [63:0] sq_v, sq_res, sq_bit;

  // CORDIC vectoring unit.
  logic signed [63:0] cx, cy, cz;
  logic [4:0]         ci;

  logic [15:0] lc, lf, lt;
  logic [17:0] lsum;
  logic [63:0] row_word;
  logic signed [63:0] map_sh, sat_val;

  assign lc = link_lengths[15:0];
  assign lf = link_lengths[31:16];
  assign lt = link_lengths[47:32];
  assign lsum = 18'(lc) + 18'(lf) + 18'(lt);
  assign row_word = frame_row[row];
  assign map_sh = m_acc >>> 14;
  assign sat_val = (map_sh > LIM_HI) ? LIM_HI : ((map_sh < LIM_LO) ? LIM_LO : map_sh);

  // Operand selection for the step about to launch.
  kind_t              op_kind;
  logic signed [63:0] op_a, op_add, op_vx, op_vy;
  logic signed [31:0] op_b;
  logic [63:0]        op_sq;

  always_comb begin
    op_kind = K_DONE;
    op_a = '0;
    op_b = '0;
    op_add = '0;
    op_vx = '0;
    op_vy = '0;
    op_sq = s_val;
    unique case (step)
      SP_MAP0: begin
        op_kind = K_MUL;
        op_a = sx16(row_word[15:0]);
        op_b = 32'(tx);
        op_add = (sx16(row_word[63:48]) <<< 14) + 64'sd8192;
      end
      SP_MAP1: begin
        op_kind = K_MUL;
        op_a = sx16(row_word[31:16]);
        op_b = 32'(ty);
        op_add = m_acc;
      end
      SP_MAP2: begin
        op_kind = K_MUL;
        op_a = sx16(row_word[47:32]);
        op_b = 32'(tz);
        op_add = m_acc;
      end
      SP_S0: begin
        op_kind = K_MUL;
        op_a = 64'(pc[0]);
        op_b = 32'(pc[0]);
      end
      SP_S1: begin
        op_kind = K_MUL;
        op_a = 64'(pc[1]);
        op_b = 32'(pc[1]);
        op_add = m_acc;
      end
      SP_SUM: begin
        op_kind = K_MUL;
        op_a = $signed({46'd0, lsum});
        op_b = $signed({14'd0, lsum});
      end
      SP_SQS: op_kind = K_SQRT;
      SP_B0: begin
        op_kind = K_MUL;
        op_a = d;
        op_b = 32'(d);
      end
      SP_B1: begin
        op_kind = K_MUL;
        op_a = 64'(pc[2]);
        op_b = 32'(pc[2]);
        op_add = m_acc;
      end
      SP_TF0: begin
        op_kind = K_MUL;
        op_a = $signed({48'd0, lt}) - $signed({48'd0, lf});
        op_b = 32'($signed({48'd0, lt}) - $signed({48'd0, lf}));
      end
      SP_TF1: begin
        op_kind = K_MUL;
        op_a = $signed({48'd0, lt}) + $signed({48'd0, lf});
        op_b = 32'($signed({48'd0, lt}) + $signed({48'd0, lf}));
      end
      SP_HALVE: op_kind = K_HALVE;
      SP_PQ: begin
        op_kind = K_MUL;
        op_a = p;
        op_b = 32'(q);
      end
      SP_SQH: op_kind = K_SQRT;
      SP_FF: begin
        op_kind = K_MUL;
        op_a = $signed({48'd0, lf});
        op_b = $signed({16'd0, lf});
        op_add = b2;
      end
      SP_TT: begin
        op_kind = K_MUL;
        op_a = $signed({48'd0, lt});
        op_b = -$signed({16'd0, lt});
        op_add = m_acc;
      end
      SP_V0: begin
        op_kind = K_VEC;
        op_vy = h2;
        op_vx = q - p;
      end
      SP_V1: begin
        op_kind = K_VEC;
        op_vy = 64'(pc[2]);
        op_vx = d;
      end
      SP_V2: begin
        op_kind = K_VEC;
        op_vy = h2;
        op_vx = u;
      end
      SP_V3: begin
        op_kind = K_VEC;
        op_vy = 64'(pc[1]);
        op_vx = 64'(pc[0]);
      end
      SP_DONE: op_kind = K_DONE;
      default: op_kind = K_DONE;
    endcase
  end

  // Unit completion terms.
  logic mul_last, sq_last, norm_more, halve_more, vec_zero, out_free, rot_last;
  logic [63:0] sq_trial;
  logic signed [63:0] xs, ys;

  assign mul_last = (m_cnt == 5'd31) || (m_plier[31:1] == 31'd0);
  assign sq_last = sq_bit[0];
  assign sq_trial = sq_res + sq_bit;
  assign norm_more = (cx < NORM_LIMIT) && (cy < NORM_LIMIT) && (cy > -NORM_LIMIT);
  assign halve_more = (p >= HALF_LIMIT) || (q >= HALF_LIMIT);
  assign vec_zero = (op_vx == 64'sd0) && (op_vy == 64'sd0);
  assign out_free = !m_tvalid || m_tready;
  assign rot_last = (ci == LAST_STEP);
  assign xs = cx >>> ci;
  assign ys = cy >>> ci;
  assign s_tready = (state == ST_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_LAUNCH;
      ST_LAUNCH: begin
        unique case (op_kind)
          K_MUL: state_next = ST_MUL;
          K_SQRT: state_next = ST_SQRT;
          K_VEC: state_next = vec_zero ? ST_STORE : ST_NORM;
          K_HALVE: state_next = ST_HALVE;
          K_DONE: state_next = ST_DONE;
          default: state_next = ST_DONE;
        endcase
      end
      ST_MUL: if (mul_last) state_next = ST_STORE;
      ST_SQRT: if (sq_last) state_next = ST_STORE;
      ST_NORM: if (!norm_more) state_next = ST_ROT;
      ST_ROT: if (rot_last) state_next = ST_STORE;
      ST_HALVE: if (!halve_more) state_next = ST_STORE;
      ST_STORE: state_next = ST_LAUNCH;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_lengths <= '0;
      frame_row[0] <= '0;
      frame_row[1] <= '0;
      frame_row[2] <= '0;
      knee_reverse <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINK_LENGTHS: link_lengths <= cfg_data[47:0];
        REG_FRAME_ROW_X: frame_row[0] <= cfg_data;
        REG_FRAME_ROW_Y: frame_row[1] <= cfg_data;
        REG_FRAME_ROW_Z: frame_row[2] <= cfg_data;
        REG_KNEE_REVERSE: knee_reverse <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Output register and held hip angle.
  logic signed [63:0] femur_o, tibia_o;
  logic [15:0]        hip_o;

  assign femur_o = knee_reverse ? -femur : femur;
  assign tibia_o = knee_reverse ? -tibia : tibia;
  assign hip_o = (pc[0] == '0) ? last_hip_angle : to16(hip_ang);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      last_hip_angle <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
        m_tuser <= ok;
        if (ok) begin
          m_tdata <= {to16(tibia_o), to16(femur_o), hip_o};
          last_hip_angle <= hip_o;
        end else begin
          m_tdata <= {32'd0, last_hip_angle};
        end
      end
    end
  end

  // Shared units and step results.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= SP_MAP0;
      row <= 2'd0;
      ok <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            tx <= s_tdata[15:0];
            ty <= s_tdata[31:16];
            tz <= s_tdata[47:32];
            step <= SP_MAP0;
            row <= 2'd0;
            ok <= 1'b1;
          end
        end
        ST_LAUNCH: begin
          unique case (op_kind)
            K_MUL: begin
              m_acc <= op_add;
              m_cand <= op_a;
              m_plier <= op_b;
              m_cnt <= 5'd0;
            end
            K_SQRT: begin
              sq_v <= op_sq;
              sq_res <= '0;
              sq_bit <= 64'd1 << 62;
            end
            K_VEC: begin
              ci <= 5'd0;
              if (vec_zero) begin
                cz <= '0;
              end else if (op_vx < 64'sd0) begin
                cz <= (op_vy >= 64'sd0) ? PI_UNITS : -PI_UNITS;
                cx <= -op_vx;
                cy <= -op_vy;
              end else begin
                cz <= '0;
                cx <= op_vx;
                cy <= op_vy;
              end
            end
            K_HALVE: sh <= 6'd0;
            K_DONE: ;
            default: ;
          endcase
        end
        // One multiplier bit per cycle; the top bit carries negative weight.
        ST_MUL: begin
          if (m_plier[0]) begin
            m_acc <= (m_cnt == 5'd31) ? (m_acc - m_cand) : (m_acc + m_cand);
          end
          m_cand <= m_cand <<< 1;
          m_plier <= m_plier >> 1;
          m_cnt <= m_cnt + 5'd1;
        end
        // One result bit per cycle.
        ST_SQRT: begin
          if (sq_v >= sq_trial) begin
            sq_v <= sq_v - sq_trial;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
        ST_NORM: begin
          if (norm_more) begin
            cx <= cx <<< 1;
            cy <= cy <<< 1;
          end
        end
        ST_ROT: begin
          if (cy >= 64'sd0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + $signed({32'd0, atan_entry(ci)});
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - $signed({32'd0, atan_entry(ci)});
          end
          ci <= ci + 5'd1;
        end
        ST_HALVE: begin
          if (halve_more) begin
            p <= p >>> 1;
            q <= q >>> 1;
            sh <= sh + 6'd1;
          end
        end
        ST_STORE: begin
          unique case (step)
            SP_MAP0: step <= SP_MAP1;
            SP_MAP1: step <= SP_MAP2;
            SP_MAP2: begin
              pc[row] <= COORD_BITS'(sat_val);
              if (row == 2'd2) begin
                step <= SP_S0;
              end else begin
                row <= row + 2'd1;
                step <= SP_MAP0;
              end
            end
            SP_S0: step <= SP_S1;
            SP_S1: begin
              s_val <= m_acc;
              step <= SP_SUM;
            end
            // Too far, or a zero femur or tibia.
            SP_SUM: begin
              if (s_val > $unsigned(m_acc) || lf == 16'd0 || lt == 16'd0) begin
                ok <= 1'b0;
                step <= SP_DONE;
              end else begin
                step <= SP_SQS;
              end
            end
            SP_SQS: begin
              d <= $signed(sq_res) - $signed({48'd0, lc});
              step <= SP_B0;
            end
            SP_B0: step <= SP_B1;
            // Zero span between femur pivot and foot.
            SP_B1: begin
              b2 <= m_acc;
              if (m_acc == 64'sd0) begin
                ok <= 1'b0;
                step <= SP_DONE;
              end else begin
                step <= SP_TF0;
              end
            end
            SP_TF0: begin
              p <= b2 - m_acc;
              step <= SP_TF1;
            end
            // Knee triangle cannot close.
            SP_TF1: begin
              q <= m_acc - b2;
              if (p < 64'sd0 || (m_acc - b2) < 64'sd0) begin
                ok <= 1'b0;
                step <= SP_DONE;
              end else begin
                step <= SP_HALVE;
              end
            end
            SP_HALVE: step <= SP_PQ;
            SP_PQ: begin
              s_val <= m_acc;
              step <= SP_SQH;
            end
            SP_SQH: begin
              h2 <= $signed(sq_res << 1);
              step <= SP_FF;
            end
            SP_FF: step <= SP_TT;
            SP_TT: begin
              u <= (m_acc <<< 1) >>> sh;
              step <= SP_V0;
            end
            SP_V0: begin
              tibia <= PI_UNITS - cz;
              step <= SP_V1;
            end
            SP_V1: begin
              femur <= cz;
              step <= SP_V2;
            end
            SP_V2: begin
              femur <= femur + cz;
              step <= (pc[0] == '0) ? SP_DONE : SP_V3;
            end
            SP_V3: begin
              hip_ang <= (pc[0] < 0) ? (cz + PI_UNITS) : cz;
              step <= SP_DONE;
            end
            SP_DONE: step <= SP_DONE;
            default: step <= SP_DONE;
          endcase
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  // An unreachable result carries zero knee angles and the held hip angle.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[47:16] == 32'd0 && m_tdata[15:0] == last_hip_angle)
    else $error("unreachable result fields wrong");

  // An accepted point starts the sequence at the frame map.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_LAUNCH && step == SP_MAP0)
    else $error("sequence did not start");

  // The rotation counter stays inside the arctangent table.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_ROT |-> ci <= LAST_STEP)
    else $error("CORDIC step out of range");

  // Halving only ever sees nonnegative cosine terms.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_HALVE |-> !p[63] && !q[63])
    else $error("negative term in halving");

  // A result is loaded only from the done step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result loaded outside done state");

endmodule

FILE: tb/tb_leg_inverse_kinematics_unit.sv
module tb_leg_inverse_kinematics_unit;
  import lik_pkg::*;

  localparam int STALL_LIMIT = 60000;
  localparam int RX_HOLD_CYCLES = 3000;
  localparam int ITEMS_PER_SETTING = 376;
  localparam longint SAT_LIM = 64'sd1 << (COORD_BITS_DEF - 1);

  typedef struct packed {
    logic        reach;
    logic [15:0] hip;
    logic [15:0] upper;
    logic [15:0] lower;
  } leg_pose_t;

  // One row of the directed table; typed rows carry their own expected pose.
  typedef struct {
    int        setup;
    int        x;
    int        y;
    int        z;
    bit        typed;
    leg_pose_t pose;
  } probe_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [47:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_LINK_LENGTHS;
  logic [63:0] cfg_data = '0;

  // Predictor copy of the configuration and the held hip angle.
  logic [47:0] links_q;
  logic [63:0] rows_q [3];
  logic        knee_rev_q;
  logic [15:0] held_hip_q;

  leg_pose_t pose_queue[$];
  int errors = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;
  int sent = 0;

  leg_inverse_kinematics_unit DUT (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sext16(input logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint int_sqrt(input longint v);
    longint res;
    longint bitv;
    res = 0;
    bitv = 64'sd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // CORDIC vectoring angle of (x, y) in 32-bit binary units.
  function automatic longint vector_angle(input longint y, input longint x);
    longint z;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_UNITS : -PI_UNITS;
      x = -x;
      y = -y;
    end
    while (x < NORM_LIMIT && y < NORM_LIMIT && y > -NORM_LIMIT) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_ENTRIES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_entry(5'(i)));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_entry(5'(i)));
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] round_angle(input longint a);
    longint r;
    r = a + 32768;
    return r[31:16];
  endfunction

  function automatic longint base_coord(input logic [63:0] row, input longint x,
                                        input longint y, input longint z);
    longint acc;
    longint p;
    acc = sext16(row[15:0]) * x + sext16(row[31:16]) * y + sext16(row[47:32]) * z
        + sext16(row[63:48]) * 16384 + 8192;
    p = acc >>> 14;
    if (p > SAT_LIM - 1) p = SAT_LIM - 1;
    if (p < -SAT_LIM) p = -SAT_LIM;
    return p;
  endfunction

  // Joint angles for one target; updates the held hip angle on success.
  function automatic leg_pose_t solve_leg(input logic [47:0] tgt);
    leg_pose_t r;
    longint x, y, z, px, py, pz, c, f, t, reach_sum, d, b2, p, q, h2, femur, tibia;
    longint ang;
    int shift;
    x = sext16(tgt[15:0]);
    y = sext16(tgt[31:16]);
    z = sext16(tgt[47:32]);
    px = base_coord(rows_q[0], x, y, z);
    py = base_coord(rows_q[1], x, y, z);
    pz = base_coord(rows_q[2], x, y, z);
    c = longint'(links_q[15:0]);
    f = longint'(links_q[31:16]);
    t = longint'(links_q[47:32]);
    reach_sum = c + f + t;
    shift = 0;
    r = '{reach: 1'b0, hip: held_hip_q, upper: 16'd0, lower: 16'd0};
    if (px * px + py * py > reach_sum * reach_sum || f == 0 || t == 0) return r;
    d = int_sqrt(px * px + py * py) - c;
    b2 = d * d + pz * pz;
    if (b2 == 0) return r;
    p = b2 - (t - f) * (t - f);
    q = (t + f) * (t + f) - b2;
    if (p < 0 || q < 0) return r;
    while (p >= 64'sd2147483648 || q >= 64'sd2147483648) begin
      p = p >>> 1;
      q = q >>> 1;
      shift++;
    end
    h2 = 2 * int_sqrt(p * q);
    tibia = PI_UNITS - vector_angle(h2, q - p);
    femur = vector_angle(pz, d) + vector_angle(h2, (2 * (f * f + b2 - t * t)) >>> shift);
    if (knee_rev_q) begin
      tibia = -tibia;
      femur = -femur;
    end
    if (px != 0) begin
      ang = vector_angle(py, px);
      if (px < 0) ang = ang + PI_UNITS;
      held_hip_q = round_angle(ang);
    end
    r.reach = 1'b1;
    r.hip = held_hip_q;
    r.upper = round_angle(femur);
    r.lower = round_angle(tibia);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Compare every result transaction with the oldest expected pose.
  always @(posedge clk) begin
    leg_pose_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pose_queue.size() == 0) begin
        report_mismatch("unexpected result", {15'd0, m_tuser}, 16'd0);
      end else begin
        want = pose_queue.pop_front();
        if (m_tuser !== want.reach) report_mismatch("reachable", {15'd0, m_tuser},
                                                    {15'd0, want.reach});
        if (m_tdata[15:0] !== want.hip) report_mismatch("hip", m_tdata[15:0], want.hip);
        if (m_tdata[31:16] !== want.upper)
          report_mismatch("upper", m_tdata[31:16], want.upper);
        if (m_tdata[47:32] !== want.lower)
          report_mismatch("lower", m_tdata[47:32], want.lower);
      end
    end
  end

  // Receiver side: random stalls plus a single long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = RX_HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else if (!rst) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Drives one register write for one cycle; the caller drops the enable.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_LINK_LENGTHS: links_q = val[47:0];
      REG_FRAME_ROW_X: rows_q[0] = val;
      REG_FRAME_ROW_Y: rows_q[1] = val;
      REG_FRAME_ROW_Z: rows_q[2] = val;
      REG_KNEE_REVERSE: knee_rev_q = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Stop offering targets and wait until every expected result has come.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] frame_row(input int r0, input int r1, input int r2,
                                            input int tr);
    return {16'(tr), 16'(r2), 16'(r1), 16'(r0)};
  endfunction

  // Load one of the leg settings used by the run.
  task automatic load_setting(input int which);
    drain_results();
    case (which)
      0: begin
        write_reg(REG_LINK_LENGTHS, {16'd0, 16'd1000, 16'd800, 16'd300});
        write_reg(REG_FRAME_ROW_X, frame_row(16384, 0, 0, 0));
        write_reg(REG_FRAME_ROW_Y, frame_row(0, 16384, 0, 0));
        write_reg(REG_FRAME_ROW_Z, frame_row(0, 0, 16384, 0));
        write_reg(REG_KNEE_REVERSE, 64'd0);
      end
      1: begin
        write_reg(REG_LINK_LENGTHS, {16'd0, 16'd1500, 16'd1500, 16'd0});
        write_reg(REG_FRAME_ROW_X, frame_row(16384, 0, 0, 100));
        write_reg(REG_FRAME_ROW_Y, frame_row(0, 16384, 0, -200));
        write_reg(REG_FRAME_ROW_Z, frame_row(0, 0, 16384, 300));
        write_reg(REG_KNEE_REVERSE, 64'd1);
      end
      2: begin
        write_reg(REG_LINK_LENGTHS, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        write_reg(REG_FRAME_ROW_X, frame_row(32767, -32768, 32767, 32767));
        write_reg(REG_FRAME_ROW_Y, frame_row(-32768, 32767, -32768, -32768));
        write_reg(REG_FRAME_ROW_Z, frame_row(0, 0, 16384, 0));
        write_reg(REG_KNEE_REVERSE, 64'd0);
      end
      3: begin
        // A quarter turn about z with a small tilt.
        write_reg(REG_LINK_LENGTHS, {16'd900, 16'd700, 16'd250, 16'd0});
        write_reg(REG_FRAME_ROW_X, frame_row(0, -16384, 0, 50));
        write_reg(REG_FRAME_ROW_Y, frame_row(16384, 0, 800, 0));
        write_reg(REG_FRAME_ROW_Z, frame_row(0, -800, 16384, -400));
        write_reg(REG_KNEE_REVERSE, 64'd1);
      end
      default: begin
        write_reg(REG_LINK_LENGTHS, {16'd1, 16'd1, 16'd0, 16'd0} | 64'h0);
        write_reg(REG_FRAME_ROW_X, frame_row(16384, 0, 0, 0));
        write_reg(REG_FRAME_ROW_Y, frame_row(0, 16384, 0, 0));
        write_reg(REG_FRAME_ROW_Z, frame_row(0, 0, 16384, 0));
        write_reg(REG_KNEE_REVERSE, 64'd0);
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  // Offer one target; the expected pose is queued on acceptance.
  task automatic send_target(input logic [47:0] tgt, input bit typed, input leg_pose_t pose);
    leg_pose_t predicted;
    s_tdata <= tgt;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = solve_leg(tgt);
    pose_queue.push_back(typed ? pose : predicted);
    sent++;
    if ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  // Mostly targets inside the leg's workspace, the rest full-range noise.
  function automatic logic [47:0] pick_target();
    longint span, tx, ty, tz;
    span = longint'(links_q[15:0]) + longint'(links_q[31:16]) + longint'(links_q[47:32]);
    if (span > 32767) span = 32767;
    if ($urandom_range(99) < 25 || span < 2)
      return {16'($urandom), 16'($urandom), 16'($urandom)};
    tx = longint'($urandom_range(2 * span)) - span - sext16(rows_q[0][63:48]);
    ty = longint'($urandom_range(2 * span)) - span - sext16(rows_q[1][63:48]);
    tz = longint'($urandom_range(span)) - span / 2 - sext16(rows_q[2][63:48]);
    return {clip16(tz), clip16(ty), clip16(tx)};
  endfunction

  probe_row_t probes[] = '{
    // After reset every link is zero, so nothing is reachable.
    '{0, 32767, 32767, 32767, 1'b1, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{0, -32768, -32768, -32768, 1'b1, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{0, 0, 0, 0, 1'b1, '{1'b0, 16'd0, 16'd0, 16'd0}},
    // Ordinary leg: plain reach, hip behind the leg, hip on the axis.
    '{1, 1000, 500, -400, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{1, -1000, 500, -200, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{1, 0, 1000, 0, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{1, 0, -1200, 300, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    // Foot right at the femur pivot, knee triangle open, and too far.
    '{1, 300, 0, 0, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{1, 400, 0, 0, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{1, 3000, 0, 0, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{1, 32767, -32768, 32767, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{1, 2100, 0, 0, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    // Fully stretched knee, mirrored knee, long links with large operands.
    '{2, 1500, 800, -900, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{2, -100, -200, 2700, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{3, 20000, 30000, -15000, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{3, -32768, 32767, 0, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{5, 1, 0, 0, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}},
    '{5, 0, 0, 1, 1'b0, '{1'b0, 16'd0, 16'd0, 16'd0}}
  };

  initial begin
    int cur_setup;
    int n;
    links_q = '0;
    rows_q[0] = '0;
    rows_q[1] = '0;
    rows_q[2] = '0;
    knee_rev_q = 1'b0;
    held_hip_q = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    cur_setup = 0;
    foreach (probes[i]) begin
      if (probes[i].setup != cur_setup) begin
        cur_setup = probes[i].setup;
        load_setting(cur_setup - 1);
      end
      send_target({16'(probes[i].z), 16'(probes[i].y), 16'(probes[i].x)},
                  probes[i].typed, probes[i].pose);
    end

    // Random part, one block per leg setting.
    n = 0;
    for (int k = 0; k < 5; k++) begin
      load_setting(k);
      for (int j = 0; j < ITEMS_PER_SETTING; j++) begin
        if (n < 630) begin
          tx_idle = 22; rx_idle = 72;
        end else if (n < 1260) begin
          tx_idle = 72; rx_idle = 22;
        end else begin
          tx_idle = 0; rx_idle = 0;
        end
        if (n == 100) hold_req = 1'b1;
        if (n == 200 || n == 1300) begin
          s_tvalid <= 1'b0;
          while (pose_queue.size() != 0) @(posedge clk);
        end
        send_target(pick_target(), 1'b0, '0);
        n++;
      end
    end
    s_tvalid <= 1'b0;

    while (pose_queue.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
